// ----- hdl/eht_pkg.sv -----
// Shared types, sizes and helpers for the extendible hash table.
// No dependencies; eht_dp, eht_ctrl and the top level import this package.
package eht_pkg;

  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int SLOTS       = 8;
  localparam int MAX_DEPTH   = 6;
  localparam int MAX_BUCKETS = 64;
  localparam int DIR_CAP     = 1 << MAX_DEPTH;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int DIR_W       = MAX_DEPTH;
  localparam int GD_W        = 3;
  localparam int FILL_W      = 4;
  localparam int USED_W      = 7;
  localparam int CNT_W       = 6;
  localparam int SLOT_AW     = BKT_W + SLOT_W;
  localparam int SIZE_W      = 7;

  localparam logic [FILL_W-1:0] LIMIT_RESET = 4'd8;
  localparam logic [FILL_W-1:0] LIMIT_MAX   = 4'd8;
  localparam logic [FILL_W-1:0] LIMIT_MIN   = 4'd1;

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [5:0]            dir_index;
  } eht_in_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic                  status;
    logic [GD_W-1:0]       global_depth_now;
    logic [SIZE_W-1:0]     directory_size;
    logic [GD_W-1:0]       local_depth;
  } eht_out_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_LOC0, S_LOC1, S_LOC2, S_SCAN_RD, S_SCAN_CMP,
    S_FIND_RD, S_FIND_VAL, S_UPDATE, S_RM_RD, S_RM_WR, S_TRY, S_APPEND, S_FULL,
    S_DBL_START, S_DBL_RD, S_DBL_W1, S_DBL_W0, S_SPLIT_START, S_SPLIT_DEP2,
    S_SPLIT_DIR, S_RED_RD, S_RED_WR, S_RED_FILL, S_RED_FILL2, S_Q0, S_Q1, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_LOC0, CMD_LOC1, CMD_LOC2, CMD_SCAN_RD,
    CMD_SCAN_CMP, CMD_FIND_RD, CMD_FIND_VAL, CMD_UPDATE, CMD_RM_RD, CMD_RM_WR,
    CMD_APPEND, CMD_FULL, CMD_DBL_START, CMD_DBL_RD, CMD_DBL_W1, CMD_DBL_W0,
    CMD_SPLIT_START, CMD_SPLIT_DEP2, CMD_SPLIT_DIR, CMD_RED_RD, CMD_RED_WR,
    CMD_RED_FILL, CMD_RED_FILL2, CMD_Q0, CMD_Q1, CMD_OUT
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  clear_last;
    logic  scan_more;
    logic  key_hit;
    logic  try_room;
    logic  at_max_buckets;
    logic  need_double;
    logic  at_max_depth;
    logic  cnt_zero;
    logic  dir_last;
    logic  red_more;
  } dp_status_t;

  // bit-reversed low gd bits of the key
  function automatic logic [DIR_W-1:0] dir_of(input logic [DIR_W-1:0] key,
                                               input logic [GD_W-1:0] gd);
    logic [DIR_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < DIR_W; j++) begin
      if (j < int'(gd)) begin
        idx[j] = key[int'(gd) - 1 - j];
      end
    end
    return idx;
  endfunction

endpackage

// ----- hdl/eht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/eht_dp.sv -----
// Datapath of the extendible hash table: directory, bucket and slot memories,
// working registers and the result register. Uses eht_pkg and eht_ram.
module eht_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  eht_pkg::cmd_t       cmd,
  input  eht_pkg::eht_in_t    in_data,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  output eht_pkg::dp_status_t sts,
  output eht_pkg::eht_out_t   out_data
);
  import eht_pkg::*;

  mode_t                 mode_r, mode_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [DIR_W-1:0]      qi_r, qi_nxt;
  logic [GD_W-1:0]       gd_r, gd_nxt;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [FILL_W-1:0]     limit_r, limit_nxt;
  logic [BKT_W-1:0]      b_r, b_nxt;
  logic [BKT_W-1:0]      nb_r, nb_nxt;
  logic [GD_W-1:0]       ld_r, ld_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIR_W-1:0]      end_r, end_nxt;
  logic [FILL_W-1:0]     fb_r, fb_nxt;
  logic [FILL_W-1:0]     fn_r, fn_nxt;
  logic                  found_r, found_nxt;
  logic                  status_r, status_nxt;
  logic [VALUE_BITS-1:0] rv_r, rv_nxt;
  eht_out_t              out_r, out_nxt;

  logic                  dir_we, dir_re;
  logic [DIR_W-1:0]      dir_waddr, dir_raddr;
  logic [BKT_W-1:0]      dir_wdata, dir_rdata;
  logic                  dep_we, dep_re;
  logic [BKT_W-1:0]      dep_waddr, dep_raddr;
  logic [GD_W-1:0]       dep_wdata, dep_rdata;
  logic                  fil_we, fil_re;
  logic [BKT_W-1:0]      fil_waddr, fil_raddr;
  logic [FILL_W-1:0]     fil_wdata, fil_rdata;
  logic                  key_we, key_re;
  logic [SLOT_AW-1:0]    key_waddr, key_raddr;
  logic [KEY_BITS-1:0]   key_wdata, key_rdata;
  logic                  val_we, val_re;
  logic [SLOT_AW-1:0]    val_waddr, val_raddr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;

  logic [DIR_W-1:0]      idx;
  logic [GD_W-1:0]       diff;
  logic [SIZE_W-1:0]     span;
  logic [DIR_W-1:0]      mask;
  logic [DIR_W-1:0]      mid;
  logic [DIR_W-1:0]      split_end;
  logic [SIZE_W-1:0]     size;
  logic [DIR_W-1:0]      qmask;
  logic [FILL_W-1:0]     limit_eff;
  logic [FILL_W-1:0]     last;

  eht_ram #(.WIDTH(BKT_W), .DEPTH(DIR_CAP)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .re(dir_re), .raddr(dir_raddr), .rdata(dir_rdata)
  );
  eht_ram #(.WIDTH(GD_W), .DEPTH(MAX_BUCKETS)) u_depth (
    .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
    .re(dep_re), .raddr(dep_raddr), .rdata(dep_rdata)
  );
  eht_ram #(.WIDTH(FILL_W), .DEPTH(MAX_BUCKETS)) u_fill (
    .clk(clk), .we(fil_we), .waddr(fil_waddr), .wdata(fil_wdata),
    .re(fil_re), .raddr(fil_raddr), .rdata(fil_rdata)
  );
  eht_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_BUCKETS * SLOTS)) u_keys (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .re(key_re), .raddr(key_raddr), .rdata(key_rdata)
  );
  eht_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_BUCKETS * SLOTS)) u_vals (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .re(val_re), .raddr(val_raddr), .rdata(val_rdata)
  );

  always_comb begin
    idx       = dir_of(key_r[DIR_W-1:0], gd_r);
    diff      = gd_r - ld_r;
    span      = SIZE_W'(1) << diff;
    mask      = DIR_W'(span - SIZE_W'(1));
    split_end = idx | mask;
    mid       = (idx & ~mask) + DIR_W'(span >> 1);
    size      = SIZE_W'(1) << gd_r;
    qmask     = DIR_W'(size - SIZE_W'(1));
    last      = fill_r - FILL_W'(1);
    if (limit_r < LIMIT_MIN) begin
      limit_eff = LIMIT_MIN;
    end else if (limit_r > LIMIT_MAX) begin
      limit_eff = LIMIT_MAX;
    end else begin
      limit_eff = limit_r;
    end
  end

  always_comb begin
    sts.mode           = mode_r;
    sts.clear_last     = (cnt_r == CNT_W'(DIR_CAP - 1));
    sts.scan_more      = (cnt_r < CNT_W'(fill_r));
    sts.key_hit        = (key_rdata == key_r);
    sts.try_room       = (fill_r < limit_eff);
    sts.at_max_buckets = (used_r >= USED_W'(MAX_BUCKETS));
    sts.need_double    = (ld_r >= gd_r);
    sts.at_max_depth   = (gd_r >= GD_W'(MAX_DEPTH));
    sts.cnt_zero       = (cnt_r == '0);
    sts.dir_last       = (cnt_r == end_r);
    sts.red_more       = (cnt_r < CNT_W'(fill_r));
  end

  always_comb begin
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    qi_nxt     = qi_r;
    gd_nxt     = gd_r;
    used_nxt   = used_r;
    limit_nxt  = cfg_we ? cfg_wdata : limit_r;
    b_nxt      = b_r;
    nb_nxt     = nb_r;
    ld_nxt     = ld_r;
    fill_nxt   = fill_r;
    cnt_nxt    = cnt_r;
    end_nxt    = end_r;
    fb_nxt     = fb_r;
    fn_nxt     = fn_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    rv_nxt     = rv_r;
    out_nxt    = out_r;
    dir_we = 1'b0; dir_waddr = '0; dir_wdata = '0; dir_re = 1'b0; dir_raddr = '0;
    dep_we = 1'b0; dep_waddr = '0; dep_wdata = '0; dep_re = 1'b0; dep_raddr = '0;
    fil_we = 1'b0; fil_waddr = '0; fil_wdata = '0; fil_re = 1'b0; fil_raddr = '0;
    key_we = 1'b0; key_waddr = '0; key_wdata = '0; key_re = 1'b0; key_raddr = '0;
    val_we = 1'b0; val_waddr = '0; val_wdata = '0; val_re = 1'b0; val_raddr = '0;
    case (cmd)
      CMD_CLEAR: begin
        dir_we = 1'b1; dir_waddr = cnt_r;
        dep_we = 1'b1; dep_waddr = cnt_r;
        fil_we = 1'b1; fil_waddr = cnt_r;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      CMD_LOAD: begin
        mode_nxt   = in_data.mode;
        key_nxt    = in_data.key;
        val_nxt    = in_data.value;
        qi_nxt     = in_data.dir_index;
        found_nxt  = 1'b0;
        status_nxt = 1'b0;
        rv_nxt     = '0;
      end
      CMD_LOC0: begin
        dir_re = 1'b1; dir_raddr = idx;
      end
      CMD_LOC1: begin
        b_nxt  = dir_rdata;
        dep_re = 1'b1; dep_raddr = dir_rdata;
        fil_re = 1'b1; fil_raddr = dir_rdata;
      end
      CMD_LOC2: begin
        ld_nxt   = dep_rdata;
        fill_nxt = fil_rdata;
        cnt_nxt  = '0;
      end
      CMD_SCAN_RD: begin
        key_re = 1'b1; key_raddr = {b_r, cnt_r[SLOT_W-1:0]};
      end
      CMD_SCAN_CMP: begin
        if (!sts.key_hit) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      CMD_FIND_RD: begin
        val_re = 1'b1; val_raddr = {b_r, cnt_r[SLOT_W-1:0]};
      end
      CMD_FIND_VAL: begin
        rv_nxt    = val_rdata;
        found_nxt = 1'b1;
      end
      CMD_UPDATE: begin
        val_we = 1'b1; val_waddr = {b_r, cnt_r[SLOT_W-1:0]}; val_wdata = val_r;
        found_nxt = 1'b1;
      end
      CMD_RM_RD: begin
        key_re = 1'b1; key_raddr = {b_r, last[SLOT_W-1:0]};
        val_re = 1'b1; val_raddr = {b_r, last[SLOT_W-1:0]};
      end
      CMD_RM_WR: begin
        key_we = 1'b1; key_waddr = {b_r, cnt_r[SLOT_W-1:0]}; key_wdata = key_rdata;
        val_we = 1'b1; val_waddr = {b_r, cnt_r[SLOT_W-1:0]}; val_wdata = val_rdata;
        fil_we = 1'b1; fil_waddr = b_r; fil_wdata = last;
        found_nxt = 1'b1;
      end
      CMD_APPEND: begin
        key_we = 1'b1; key_waddr = {b_r, fill_r[SLOT_W-1:0]}; key_wdata = key_r;
        val_we = 1'b1; val_waddr = {b_r, fill_r[SLOT_W-1:0]}; val_wdata = val_r;
        fil_we = 1'b1; fil_waddr = b_r; fil_wdata = fill_r + FILL_W'(1);
      end
      CMD_FULL: begin
        status_nxt = 1'b1;
      end
      CMD_DBL_START: begin
        cnt_nxt = CNT_W'(size - SIZE_W'(1));
      end
      CMD_DBL_RD: begin
        dir_re = 1'b1; dir_raddr = cnt_r;
      end
      CMD_DBL_W1: begin
        dir_we = 1'b1; dir_waddr = {cnt_r[DIR_W-2:0], 1'b1}; dir_wdata = dir_rdata;
      end
      CMD_DBL_W0: begin
        dir_we = 1'b1; dir_waddr = {cnt_r[DIR_W-2:0], 1'b0}; dir_wdata = dir_rdata;
        if (sts.cnt_zero) begin
          gd_nxt = gd_r + GD_W'(1);
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      CMD_SPLIT_START: begin
        nb_nxt   = used_r[BKT_W-1:0];
        used_nxt = used_r + USED_W'(1);
        end_nxt  = split_end;
        cnt_nxt  = mid;
        dep_we = 1'b1; dep_waddr = b_r; dep_wdata = ld_r + GD_W'(1);
      end
      CMD_SPLIT_DEP2: begin
        dep_we = 1'b1; dep_waddr = nb_r; dep_wdata = ld_r + GD_W'(1);
      end
      CMD_SPLIT_DIR: begin
        dir_we = 1'b1; dir_waddr = cnt_r; dir_wdata = nb_r;
        if (sts.dir_last) begin
          cnt_nxt = '0;
          fb_nxt  = '0;
          fn_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      CMD_RED_RD: begin
        key_re = 1'b1; key_raddr = {b_r, cnt_r[SLOT_W-1:0]};
        val_re = 1'b1; val_raddr = {b_r, cnt_r[SLOT_W-1:0]};
      end
      CMD_RED_WR: begin
        key_we = 1'b1; key_wdata = key_rdata;
        val_we = 1'b1; val_wdata = val_rdata;
        if (key_rdata[ld_r]) begin
          key_waddr = {nb_r, fn_r[SLOT_W-1:0]};
          val_waddr = {nb_r, fn_r[SLOT_W-1:0]};
          fn_nxt    = fn_r + FILL_W'(1);
        end else begin
          key_waddr = {b_r, fb_r[SLOT_W-1:0]};
          val_waddr = {b_r, fb_r[SLOT_W-1:0]};
          fb_nxt    = fb_r + FILL_W'(1);
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      CMD_RED_FILL: begin
        fil_we = 1'b1; fil_waddr = b_r; fil_wdata = fb_r;
      end
      CMD_RED_FILL2: begin
        fil_we = 1'b1; fil_waddr = nb_r; fil_wdata = fn_r;
      end
      CMD_Q0: begin
        dir_re = 1'b1; dir_raddr = qi_r & qmask;
      end
      CMD_Q1: begin
        dep_re = 1'b1; dep_raddr = dir_rdata;
      end
      CMD_OUT: begin
        out_nxt.found            = found_r;
        out_nxt.read_value       = rv_r;
        out_nxt.status           = status_r;
        out_nxt.global_depth_now = gd_r;
        out_nxt.directory_size   = size;
        out_nxt.local_depth      = dep_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gd_r    <= '0;
      used_r  <= USED_W'(1);
      limit_r <= LIMIT_RESET;
      cnt_r   <= '0;
    end else begin
      gd_r    <= gd_nxt;
      used_r  <= used_nxt;
      limit_r <= limit_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    qi_r     <= qi_nxt;
    b_r      <= b_nxt;
    nb_r     <= nb_nxt;
    ld_r     <= ld_nxt;
    fill_r   <= fill_nxt;
    end_r    <= end_nxt;
    fb_r     <= fb_nxt;
    fn_r     <= fn_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    rv_r     <= rv_nxt;
    out_r    <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ----- hdl/eht_ctrl.sv -----
// Controller state machine of the extendible hash table: sequences lookups,
// splits, directory doubling and the result handshake. Uses eht_pkg.
module eht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  eht_pkg::dp_status_t sts,
  output eht_pkg::cmd_t       cmd
);
  import eht_pkg::*;

  state_t state_r, state_nxt;
  logic   retry_r, retry_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    retry_nxt     = retry_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
          retry_nxt = 1'b0;
        end
      end
      S_DISPATCH: begin
        state_nxt = (sts.mode == MODE_QUERY) ? S_Q0 : S_LOC0;
      end
      S_LOC0: state_nxt = S_LOC1;
      S_LOC1: state_nxt = S_LOC2;
      S_LOC2: state_nxt = retry_r ? S_TRY : S_SCAN_RD;
      S_SCAN_RD: begin
        if (sts.scan_more) begin
          state_nxt = S_SCAN_CMP;
        end else if (sts.mode == MODE_INSERT) begin
          state_nxt = S_TRY;
        end else begin
          state_nxt = S_Q0;
        end
      end
      S_SCAN_CMP: begin
        if (!sts.key_hit) begin
          state_nxt = S_SCAN_RD;
        end else if (sts.mode == MODE_FIND) begin
          state_nxt = S_FIND_RD;
        end else if (sts.mode == MODE_INSERT) begin
          state_nxt = S_UPDATE;
        end else begin
          state_nxt = S_RM_RD;
        end
      end
      S_FIND_RD:  state_nxt = S_FIND_VAL;
      S_FIND_VAL: state_nxt = S_Q0;
      S_UPDATE:   state_nxt = S_Q0;
      S_RM_RD:    state_nxt = S_RM_WR;
      S_RM_WR:    state_nxt = S_Q0;
      S_TRY: begin
        retry_nxt = 1'b1;
        if (sts.try_room) begin
          state_nxt = S_APPEND;
        end else if (sts.at_max_buckets) begin
          state_nxt = S_FULL;
        end else if (sts.need_double) begin
          state_nxt = sts.at_max_depth ? S_FULL : S_DBL_START;
        end else begin
          state_nxt = S_SPLIT_START;
        end
      end
      S_APPEND:      state_nxt = S_Q0;
      S_FULL:        state_nxt = S_Q0;
      S_DBL_START:   state_nxt = S_DBL_RD;
      S_DBL_RD:      state_nxt = S_DBL_W1;
      S_DBL_W1:      state_nxt = S_DBL_W0;
      S_DBL_W0:      state_nxt = sts.cnt_zero ? S_SPLIT_START : S_DBL_RD;
      S_SPLIT_START: state_nxt = S_SPLIT_DEP2;
      S_SPLIT_DEP2:  state_nxt = S_SPLIT_DIR;
      S_SPLIT_DIR: begin
        if (sts.dir_last) state_nxt = S_RED_RD;
      end
      S_RED_RD:    state_nxt = sts.red_more ? S_RED_WR : S_RED_FILL;
      S_RED_WR:    state_nxt = S_RED_RD;
      S_RED_FILL:  state_nxt = S_RED_FILL2;
      S_RED_FILL2: state_nxt = S_LOC0;
      S_Q0:        state_nxt = S_Q1;
      S_Q1:        state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = CMD_NONE;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: cmd = CMD_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      S_LOC0:        cmd = CMD_LOC0;
      S_LOC1:        cmd = CMD_LOC1;
      S_LOC2:        cmd = CMD_LOC2;
      S_SCAN_RD:     cmd = sts.scan_more ? CMD_SCAN_RD : CMD_NONE;
      S_SCAN_CMP:    cmd = CMD_SCAN_CMP;
      S_FIND_RD:     cmd = CMD_FIND_RD;
      S_FIND_VAL:    cmd = CMD_FIND_VAL;
      S_UPDATE:      cmd = CMD_UPDATE;
      S_RM_RD:       cmd = CMD_RM_RD;
      S_RM_WR:       cmd = CMD_RM_WR;
      S_APPEND:      cmd = CMD_APPEND;
      S_FULL:        cmd = CMD_FULL;
      S_DBL_START:   cmd = CMD_DBL_START;
      S_DBL_RD:      cmd = CMD_DBL_RD;
      S_DBL_W1:      cmd = CMD_DBL_W1;
      S_DBL_W0:      cmd = CMD_DBL_W0;
      S_SPLIT_START: cmd = CMD_SPLIT_START;
      S_SPLIT_DEP2:  cmd = CMD_SPLIT_DEP2;
      S_SPLIT_DIR:   cmd = CMD_SPLIT_DIR;
      S_RED_RD:      cmd = sts.red_more ? CMD_RED_RD : CMD_NONE;
      S_RED_WR:      cmd = CMD_RED_WR;
      S_RED_FILL:    cmd = CMD_RED_FILL;
      S_RED_FILL2:   cmd = CMD_RED_FILL2;
      S_Q0:          cmd = CMD_Q0;
      S_Q1:          cmd = CMD_Q1;
      S_DONE:        cmd = out_free ? CMD_OUT : CMD_NONE;
      default:       cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      retry_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      retry_r     <= retry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready)
    else $error("request taken during clearing pass");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after completion");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DISPATCH)
    else $error("accepted request not dispatched");

  a_retry_to_try: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOC2 && retry_r) |=> state_r == S_TRY)
    else $error("insert retry skipped bucket check");
`endif

endmodule

// ----- hdl/extendible_hash_table.sv -----
// Extendible hash table top level: controller plus datapath.
// Uses eht_pkg, eht_ctrl and eht_dp.
//
// One request at a time. After reset a clearing pass zeroes all 64 entries of
// the directory and bucket tables before the first request is taken. Find,
// remove and update scan up to 8 slots of the bucket; an append follows the
// scan of an insert that misses. Each split rewrites the moved directory
// entries at one per cycle and redistributes the bucket slot by slot; a
// directory doubling copies each old entry into two. Each table has a single
// read port. The result register frees the input side as soon as a result is
// loaded into it; the next result waits until the previous one is taken.
module extendible_hash_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  eht_pkg::eht_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output eht_pkg::eht_out_t out_data,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);
  import eht_pkg::*;

  cmd_t       cmd;
  dp_status_t sts;

  eht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  eht_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .sts(sts), .out_data(out_data)
  );

endmodule
